### rtl/gcdcf_pkg.sv
// ----------------------------------------------------------------------------
// gcdcf_pkg
// Shared types, constants and the single binary gcd step for the gcd pipeline.
// ----------------------------------------------------------------------------
package gcdcf_pkg;

  localparam int unsigned PortWidth    = 32;
  localparam int unsigned OperandWidth = 32;
  localparam int unsigned ShiftWidth   = (OperandWidth > 2) ? $clog2(OperandWidth) : 1;
  localparam int unsigned NumSteps     = 2 * OperandWidth;

  typedef logic [PortWidth-1:0]    port_word_t;
  typedef logic [OperandWidth-1:0] operand_t;
  typedef logic [ShiftWidth-1:0]   shift_t;

  typedef struct packed {
    logic     nz;
    operand_t a;
    operand_t b;
    shift_t   k;
  } gcd_data_t;

  // one step: remove a common factor of two, a lone factor of two, or
  // replace the larger odd operand by half the difference
  function automatic gcd_data_t gcd_step(gcd_data_t d);
    gcd_data_t r;
    operand_t  diff_ab;
    operand_t  diff_ba;
    r       = d;
    diff_ab = d.a - d.b;
    diff_ba = d.b - d.a;
    if (d.a != '0 && d.b != '0) begin
      if (!d.a[0] && !d.b[0]) begin
        r.a = d.a >> 1;
        r.b = d.b >> 1;
        r.k = d.k + 1'b1;
      end else if (!d.a[0]) begin
        r.a = d.a >> 1;
      end else if (!d.b[0]) begin
        r.b = d.b >> 1;
      end else if (d.a >= d.b) begin
        r.a = diff_ab >> 1;
      end else begin
        r.b = diff_ba >> 1;
      end
    end
    return r;
  endfunction

endpackage

### rtl/gcd_with_coprime_flag.sv
// ----------------------------------------------------------------------------
// gcd_with_coprime_flag
// Pipeline: input register, 64 binary gcd step stages, output register with
// the final shift.
// Throughput: one request per cycle; the whole pipeline holds while the
// result register waits on out_stall_i.
// Reset: rst_ni clears all valid bits asynchronously; data is not reset.
// ----------------------------------------------------------------------------
module gcd_with_coprime_flag (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  gcdcf_pkg::port_word_t first_operand_i,
  input  gcdcf_pkg::port_word_t second_operand_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output gcdcf_pkg::port_word_t divisor_o,
  output logic                  coprime_o,
  output logic                  valid_res_o
);
  import gcdcf_pkg::*;

  logic       adv;
  gcd_data_t  in_data;
  operand_t   gcd_val;
  logic       valid_q [NumSteps+1];
  gcd_data_t  data_q  [NumSteps+1];
  logic       out_valid_q;
  port_word_t divisor_q;
  logic       coprime_q;
  logic       valid_res_q;

  assign adv        = !(out_valid_q && out_stall_i);
  assign in_stall_o = !adv;

  always_comb begin
    in_data.a  = operand_t'(first_operand_i);
    in_data.b  = operand_t'(second_operand_i);
    in_data.nz = (in_data.a != '0) && (in_data.b != '0);
    in_data.k  = '0;
  end

  assign gcd_val = (data_q[NumSteps].a | data_q[NumSteps].b) << data_q[NumSteps].k;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i <= NumSteps; i++) begin
        valid_q[i] <= 1'b0;
      end
      out_valid_q <= 1'b0;
    end else if (adv) begin
      valid_q[0] <= in_valid_i;
      for (int i = 1; i <= NumSteps; i++) begin
        valid_q[i] <= valid_q[i-1];
      end
      out_valid_q <= valid_q[NumSteps];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      data_q[0] <= in_data;
      for (int i = 1; i <= NumSteps; i++) begin
        data_q[i] <= gcd_step(data_q[i-1]);
      end
      divisor_q   <= data_q[NumSteps].nz ? port_word_t'(gcd_val) : '0;
      coprime_q   <= data_q[NumSteps].nz && (gcd_val == operand_t'(1));
      valid_res_q <= data_q[NumSteps].nz;
    end
  end

  assign out_valid_o = out_valid_q;
  assign divisor_o   = divisor_q;
  assign coprime_o   = coprime_q;
  assign valid_res_o = valid_res_q;

endmodule

### rtl/gcdcf_checker.sv
// ----------------------------------------------------------------------------
// gcdcf_checker
// Port level checks for the gcd pipeline, bound to the top level.
// ----------------------------------------------------------------------------
module gcdcf_checker (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_stall_o,
  input logic                  out_valid_o,
  input logic                  out_stall_i,
  input gcdcf_pkg::port_word_t divisor_o,
  input logic                  coprime_o,
  input logic                  valid_res_o
);

  // a stalled result stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // requests are held back only by a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("request stalled without backpressure");

  // zero operand gives an all-zero result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !valid_res_o |-> divisor_o == '0 && !coprime_o)
    else $error("invalid result not cleared");

  // coprime means a divisor of one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && coprime_o |-> valid_res_o && divisor_o == 1)
    else $error("coprime flag without unit divisor");

  // a valid gcd is never zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && valid_res_o |-> divisor_o != '0)
    else $error("zero divisor on valid result");

endmodule

bind gcd_with_coprime_flag gcdcf_checker u_gcdcf_checker (.*);
